>>> src/rxd_pkg.sv
`timescale 1ns / 1ps
package rxd_pkg;

  localparam int DefLevelBits = 8;
  localparam int DefCoefBits  = 24;
  localparam int LvlInW       = 8;
  localparam int ValInW       = 24;
  localparam int VecW         = 16;
  localparam int NumTables    = 7;
  localparam int NumSlots     = 6;
  localparam int FifoDepth    = 4;
  localparam int CfgIdxW      = 2;

  typedef enum logic [1:0] {
    REQ_LOAD_COEF = 2'd0,
    REQ_LOAD_VEC  = 2'd1,
    REQ_CONVERT   = 2'd2,
    REQ_NONE      = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    TBL_RED     = 3'd0,
    TBL_GREEN   = 3'd1,
    TBL_BLUE    = 3'd2,
    TBL_CYAN    = 3'd3,
    TBL_MAGENTA = 3'd4,
    TBL_YELLOW  = 3'd5,
    TBL_GRAY    = 3'd6
  } tbl_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OFFSET_X = 2'd0,
    CFG_OFFSET_Y = 2'd1,
    CFG_OFFSET_Z = 2'd2
  } cfg_e;

  // Classified work item handed from the front to the back.
  typedef struct packed {
    req_e               op;
    logic [2:0]         tsel;
    logic               pick;
    logic [LvlInW-1:0]  level;
    logic [2:0]         slot;
    logic [ValInW-1:0]  value;
    logic [LvlInW-1:0]  lo;
    logic [LvlInW-1:0]  mid;
    logic [LvlInW-1:0]  hi;
    logic [2:0]         sec;
    logic [2:0]         pri;
  } entry_t;

endpackage

>>> src/rxd_ram.sv
`timescale 1ns / 1ps
module rxd_ram #(
  parameter int Width = 16,
  parameter int Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

>>> src/rxd_fifo.sv
`timescale 1ns / 1ps
module rxd_fifo
  import rxd_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t head_o
);

  localparam int PtrW = $clog2(FifoDepth);

  entry_t          buf_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (PtrW + 1)'(FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> src/rxd_front.sv
`timescale 1ns / 1ps
module rxd_front
  import rxd_pkg::*;
#(
  parameter int LEVEL_BITS = DefLevelBits
) (
  input  logic [1:0]        req_type_i,
  input  logic [2:0]        table_sel_i,
  input  logic              coef_pick_i,
  input  logic [LvlInW-1:0] level_i,
  input  logic [2:0]        vector_slot_i,
  input  logic [ValInW-1:0] load_value_i,
  input  logic [LvlInW-1:0] red_level_i,
  input  logic [LvlInW-1:0] green_level_i,
  input  logic [LvlInW-1:0] blue_level_i,
  output entry_t            entry_o
);

  logic [LEVEL_BITS-1:0] r, g, b;
  logic                  tsel_ok;

  // Compare only the live level bits.
  assign r = LEVEL_BITS'(red_level_i);
  assign g = LEVEL_BITS'(green_level_i);
  assign b = LEVEL_BITS'(blue_level_i);
  assign tsel_ok = (table_sel_i <= TBL_GRAY);

  always_comb begin
    entry_o       = '0;
    entry_o.tsel  = table_sel_i;
    entry_o.pick  = coef_pick_i;
    entry_o.level = level_i;
    entry_o.slot  = vector_slot_i;
    entry_o.value = load_value_i;
    unique case (req_e'(req_type_i))
      REQ_LOAD_COEF: entry_o.op = tsel_ok ? REQ_LOAD_COEF : REQ_NONE;
      REQ_LOAD_VEC:  entry_o.op = (tsel_ok && vector_slot_i < 3'(NumSlots)) ?
                                  REQ_LOAD_VEC : REQ_NONE;
      REQ_CONVERT:   entry_o.op = REQ_CONVERT;
      default:       entry_o.op = REQ_NONE;
    endcase
    // Pick the path from the strict ordering of the levels.
    if (r > g && r > b) begin
      entry_o.pri = TBL_RED;
      entry_o.hi  = red_level_i;
      if (g > b) begin
        entry_o.lo = blue_level_i; entry_o.mid = green_level_i; entry_o.sec = TBL_YELLOW;
      end else begin
        entry_o.lo = green_level_i; entry_o.mid = blue_level_i; entry_o.sec = TBL_MAGENTA;
      end
    end else if (g > b) begin
      entry_o.pri = TBL_GREEN;
      entry_o.hi  = green_level_i;
      if (r > b) begin
        entry_o.lo = blue_level_i; entry_o.mid = red_level_i; entry_o.sec = TBL_YELLOW;
      end else begin
        entry_o.lo = red_level_i; entry_o.mid = blue_level_i; entry_o.sec = TBL_CYAN;
      end
    end else begin
      entry_o.pri = TBL_BLUE;
      entry_o.hi  = blue_level_i;
      if (r > g) begin
        entry_o.lo = green_level_i; entry_o.mid = red_level_i; entry_o.sec = TBL_MAGENTA;
      end else begin
        entry_o.lo = red_level_i; entry_o.mid = green_level_i; entry_o.sec = TBL_CYAN;
      end
    end
  end

endmodule

>>> src/rxd_back.sv
`timescale 1ns / 1ps
module rxd_back
  import rxd_pkg::*;
#(
  parameter int LEVEL_BITS = DefLevelBits,
  parameter int COEF_BITS  = DefCoefBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  entry_t              head_i,
  output logic                pop_o,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                status_o,
  output logic signed [31:0]  x_value_o,
  output logic signed [31:0]  y_value_o,
  output logic signed [31:0]  z_value_o
);

  localparam int CoefDepth = NumTables << LEVEL_BITS;
  localparam int CoefAw    = $clog2(CoefDepth);
  localparam int VecAw     = $clog2(NumTables);
  localparam int ProdW     = COEF_BITS + VecW;
  localparam int ShW       = ProdW - 15;
  localparam int TermW     = ShW + 1;
  localparam int AccW      = COEF_BITS + 16;

  typedef struct packed {
    logic valid;
    logic conv;
    logic phase;
  } ctrl_t;

  logic               adv;
  logic               phase_q;
  logic               issue, is_conv;
  logic signed [31:0] offset_q [3];

  logic [CoefAw-1:0]  ca_addr [2];
  logic [CoefAw-1:0]  cb_addr [2];
  logic [CoefAw-1:0]  coef_waddr;
  logic [VecAw-1:0]   va_addr, vb_addr;
  logic [COEF_BITS-1:0] coef_wdata;
  logic               coef_we, vec_we;

  logic [COEF_BITS-1:0] p_raw [2][2];
  logic [COEF_BITS-1:0] s_raw [2][2];
  logic [VecW-1:0]      va_raw [NumSlots];
  logic [VecW-1:0]      vb_raw [NumSlots];

  ctrl_t              s1_q, s2_q;
  logic signed [TermW-1:0] term_q [4][3];
  logic signed [AccW-1:0]  acc_q [3];
  logic signed [AccW-1:0]  sum [3];
  logic signed [AccW-1:0]  total [3];

  logic               out_valid_q, status_q;
  logic signed [31:0] res_q [3];

  // Advance the whole back end whenever the output register can move.
  assign adv     = !out_valid_q || out_ready_i;
  assign issue   = adv && head_valid_i;
  assign is_conv = (head_i.op == REQ_CONVERT);
  assign pop_o   = issue && (!is_conv || phase_q);

  // Lookup addresses: phase 0 reads sec@mid, sec@lo, pri@hi, pri@mid; phase 1 gray@lo.
  always_comb begin
    ca_addr[0] = phase_q ? {3'(TBL_GRAY), LEVEL_BITS'(head_i.lo)}
                         : {head_i.sec, LEVEL_BITS'(head_i.mid)};
    cb_addr[0] = {head_i.sec, LEVEL_BITS'(head_i.lo)};
    ca_addr[1] = {head_i.pri, LEVEL_BITS'(head_i.hi)};
    cb_addr[1] = {head_i.pri, LEVEL_BITS'(head_i.mid)};
    va_addr    = phase_q ? VecAw'(TBL_GRAY) : VecAw'(head_i.sec);
    vb_addr    = VecAw'(head_i.pri);
    coef_waddr = {head_i.tsel, LEVEL_BITS'(head_i.level)};
    coef_wdata = COEF_BITS'($signed(head_i.value));
    coef_we    = issue && (head_i.op == REQ_LOAD_COEF);
    vec_we     = issue && (head_i.op == REQ_LOAD_VEC);
  end

  // Two copies of each coefficient bank give four lookups per cycle while the back end advances.
  for (genvar cp = 0; cp < 2; cp++) begin : g_copy
    rxd_ram #(.Width(COEF_BITS), .Depth(CoefDepth)) u_pri (
      .clk_i, .we_i(coef_we && !head_i.pick), .waddr_i(coef_waddr),
      .wdata_i(coef_wdata), .re_i(adv),
      .raddr_a_i(ca_addr[cp]), .raddr_b_i(cb_addr[cp]),
      .rdata_a_o(p_raw[cp][0]), .rdata_b_o(p_raw[cp][1])
    );
    rxd_ram #(.Width(COEF_BITS), .Depth(CoefDepth)) u_sec (
      .clk_i, .we_i(coef_we && head_i.pick), .waddr_i(coef_waddr),
      .wdata_i(coef_wdata), .re_i(adv),
      .raddr_a_i(ca_addr[cp]), .raddr_b_i(cb_addr[cp]),
      .rdata_a_o(s_raw[cp][0]), .rdata_b_o(s_raw[cp][1])
    );
  end

  for (genvar sl = 0; sl < NumSlots; sl++) begin : g_vec
    rxd_ram #(.Width(VecW), .Depth(NumTables)) u_vec (
      .clk_i, .we_i(vec_we && head_i.slot == 3'(sl)), .waddr_i(VecAw'(head_i.tsel)),
      .wdata_i(head_i.value[VecW-1:0]), .re_i(adv),
      .raddr_a_i(va_addr), .raddr_b_i(vb_addr),
      .rdata_a_o(va_raw[sl]), .rdata_b_o(vb_raw[sl])
    );
  end

  // Multiply stage: lookups 0,1 use the first vector port, 2,3 the second.
  for (genvar k = 0; k < 4; k++) begin : g_look
    for (genvar ch = 0; ch < 3; ch++) begin : g_ch
      logic signed [ProdW-1:0] pp, sp;
      logic signed [VecW-1:0]  vp, vs;
      assign vp = $signed(k < 2 ? va_raw[ch] : vb_raw[ch]);
      assign vs = $signed(k < 2 ? va_raw[ch+3] : vb_raw[ch+3]);
      assign pp = ProdW'($signed(p_raw[k/2][k%2])) * ProdW'(vp);
      assign sp = ProdW'($signed(s_raw[k/2][k%2])) * ProdW'(vs);
      always_ff @(posedge clk_i) begin
        if (adv) begin
          term_q[k][ch] <= TermW'($signed(pp[ProdW-1:15]))
                         + TermW'($signed(sp[ProdW-1:15]));
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      if (s2_q.phase) begin
        sum[ch] = AccW'(term_q[0][ch]);
      end else begin
        sum[ch] = AccW'(term_q[0][ch]) - AccW'(term_q[1][ch])
                + AccW'(term_q[2][ch]) - AccW'(term_q[3][ch]);
      end
      total[ch] = acc_q[ch] + sum[ch];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_q.valid && s2_q.conv && !s2_q.phase) begin
      for (int ch = 0; ch < 3; ch++) begin
        acc_q[ch] <= AccW'(offset_q[ch]) + sum[ch];
      end
    end
    if (adv && s2_q.valid && (!s2_q.conv || s2_q.phase)) begin
      status_q <= s2_q.conv;
      for (int ch = 0; ch < 3; ch++) begin
        if (!s2_q.conv) begin
          res_q[ch] <= '0;
        end else if (total[ch][AccW-1:31] == '0 || total[ch][AccW-1:31] == '1) begin
          res_q[ch] <= total[ch][31:0];
        end else begin
          res_q[ch] <= total[ch][AccW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      s1_q        <= '0;
      s2_q        <= '0;
      out_valid_q <= 1'b0;
      offset_q[0] <= '0;
      offset_q[1] <= '0;
      offset_q[2] <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_e'(cfg_index_i))
          CFG_OFFSET_X: offset_q[0] <= cfg_data_i;
          CFG_OFFSET_Y: offset_q[1] <= cfg_data_i;
          CFG_OFFSET_Z: offset_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
      if (adv) begin
        if (issue && is_conv) begin
          phase_q <= !phase_q;
        end
        s1_q        <= '{valid: issue, conv: is_conv, phase: phase_q};
        s2_q        <= s1_q;
        out_valid_q <= s2_q.valid && (!s2_q.conv || s2_q.phase);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign x_value_o   = res_q[0];
  assign y_value_o   = res_q[1];
  assign z_value_o   = res_q[2];

endmodule

>>> src/rgb_to_xyz_display_model.sv
`timescale 1ns / 1ps
// Path: items pass from the queue through the table read, term and output registers.
// Throughput: one load item per cycle while results are taken; a pixel is issued in two
//   phases, the duplicated dual-read banks giving four lookups per cycle (five per pixel).
// Reset: control, queue and offset registers clear; coefficient and projection
//   tables are undefined until loaded.
module rgb_to_xyz_display_model
  import rxd_pkg::*;
#(
  parameter int LEVEL_BITS = DefLevelBits,
  parameter int COEF_BITS  = DefCoefBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Item input channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          req_type_i,
  input  logic [2:0]          table_sel_i,
  input  logic                coef_pick_i,
  input  logic [LvlInW-1:0]   level_i,
  input  logic [2:0]          vector_slot_i,
  input  logic signed [ValInW-1:0] load_value_i,
  input  logic [LvlInW-1:0]   red_level_i,
  input  logic [LvlInW-1:0]   green_level_i,
  input  logic [LvlInW-1:0]   blue_level_i,
  // Result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                status_o,
  output logic signed [31:0]  x_value_o,
  output logic signed [31:0]  y_value_o,
  output logic signed [31:0]  z_value_o,
  // Configuration writes, always taken
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  entry_t entry, head;
  logic   full, head_valid, pop;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !full;

  // Front: sort the levels and pick the tetrahedral path, or decode the load.
  rxd_front #(.LEVEL_BITS(LEVEL_BITS)) u_front (
    .req_type_i, .table_sel_i, .coef_pick_i, .level_i, .vector_slot_i,
    .load_value_i(load_value_i), .red_level_i, .green_level_i, .blue_level_i,
    .entry_o(entry)
  );

  // Short queue decouples acceptance from the table pipeline.
  rxd_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(in_valid_i && !full), .push_data_i(entry), .full_o(full),
    .pop_i(pop), .valid_o(head_valid), .head_o(head)
  );

  // Back: table writes, lookups, multiply, accumulate, saturate.
  rxd_back #(.LEVEL_BITS(LEVEL_BITS), .COEF_BITS(COEF_BITS)) u_back (
    .clk_i, .rst_ni,
    .head_valid_i(head_valid), .head_i(head), .pop_o(pop),
    .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .out_valid_o, .out_ready_i, .status_o, .x_value_o, .y_value_o, .z_value_o
  );

endmodule
